[hdl/spmv_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the CSR sparse matrix-vector multiply core.
// Used by the controller, the datapath and the top level; no dependencies.
package spmv_pkg;

  // Store sizes; the stream field widths are built around these values.
  localparam int MAX_ROWS     = 256;
  localparam int MAX_COLS     = 256;
  localparam int MAX_NONZEROS = 1024;

  localparam logic [2:0] OP_LOAD_X   = 3'd0;
  localparam logic [2:0] OP_LOAD_Y   = 3'd1;
  localparam logic [2:0] OP_LOAD_PTR = 3'd2;
  localparam logic [2:0] OP_LOAD_NZ  = 3'd3;
  localparam logic [2:0] OP_COMPUTE  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_IDX = 2'd1;
  localparam logic [1:0] ST_BAD_COL = 2'd2;

  localparam logic [1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [1:0] REG_NUM_COLS = 2'd1;
  localparam logic [1:0] REG_ALPHA    = 2'd2;
  localparam logic [1:0] REG_BETA     = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the accepted transaction
    logic do_load;    // perform the load write
    logic rd_ptr0;    // read row start
    logic rd_ptr1;    // read row end
    logic walk_rd;    // issue nonzero read at cursor, advance cursor
    logic x_rd;       // read x at fetched column
    logic mac;        // accumulate rounded product
    logic clip_dot;   // clip dot into its register
    logic scale_y;    // alpha and beta multiplies
    logic finish;     // sum, clip, write back y, load output
    logic fail_idx;   // load error output, status index
    logic fail_col;   // load error output, status column
    logic load_done;  // load the output register for a load item
  } spmv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_compute;
    logic op_known;
    logic load_ok;
    logic row_ok;
    logic ptr_ok;
    logic walk_more;
    logic col_ok;
  } spmv_stat_t;

endpackage

[hdl/spmv_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine for the CSR multiply core.
// Depends on spmv_pkg for the command and status structs.
module spmv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic                 out_free,
  input  spmv_pkg::spmv_stat_t stat,
  output spmv_pkg::spmv_cmd_t  cmd,
  output logic                 busy
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DEC   = 11'b00000000010,
    S_PTR0  = 11'b00000000100,
    S_PTR1  = 11'b00000001000,
    S_CHK   = 11'b00000010000,
    S_NZ    = 11'b00000100000,
    S_XRD   = 11'b00001000000,
    S_MAC   = 11'b00010000000,
    S_DOT   = 11'b00100000000,
    S_BETA  = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (out_free) begin
          if (!stat.is_compute) begin
            cmd.do_load = stat.op_known & stat.load_ok;
            cmd.load_done = 1'b1;
            state_next = S_IDLE;
          end else if (!stat.row_ok) begin
            cmd.fail_idx = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.rd_ptr0 = 1'b1;
            state_next = S_PTR0;
          end
        end
      end
      S_PTR0: begin
        cmd.rd_ptr1 = 1'b1;
        state_next = S_PTR1;
      end
      S_PTR1: state_next = S_CHK;
      S_CHK: begin
        if (!stat.ptr_ok) begin
          cmd.fail_idx = 1'b1;
          state_next = S_IDLE;
        end else if (stat.walk_more) begin
          cmd.walk_rd = 1'b1;
          state_next = S_NZ;
        end else begin
          state_next = S_DOT;
        end
      end
      S_NZ: begin
        cmd.x_rd = 1'b1;
        state_next = S_XRD;
      end
      S_XRD: begin
        if (!stat.col_ok) begin
          cmd.fail_col = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        state_next = S_CHK;
      end
      S_DOT: begin
        cmd.clip_dot = 1'b1;
        state_next = S_BETA;
      end
      S_BETA: begin
        cmd.scale_y = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

[hdl/spmv_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the CSR multiply core: vector, pointer and nonzero memories,
// accumulator, scaling multipliers and output register. Depends on spmv_pkg.
module spmv_datapath (
  input  logic                clk,
  input  logic                rst,
  input  spmv_pkg::spmv_cmd_t cmd,
  output spmv_pkg::spmv_stat_t stat,
  input  logic [2:0]          in_op,
  input  logic [10:0]         in_index,
  input  logic [7:0]          in_column,
  input  logic signed [31:0]  in_value,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [31:0]         cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [7:0]          out_row,
  output logic signed [31:0]  out_result,
  output logic                out_sat,
  output logic [1:0]          out_status
);

  localparam int CW = $clog2(spmv_pkg::MAX_COLS);
  localparam int RAW = $clog2(spmv_pkg::MAX_ROWS);
  localparam int PW = $clog2(spmv_pkg::MAX_ROWS + 1);
  localparam int NW = $clog2(spmv_pkg::MAX_NONZEROS);
  localparam int NPW = $clog2(spmv_pkg::MAX_NONZEROS + 1);

  // Configuration
  logic [8:0] row_count, col_count;
  logic signed [31:0] alpha, beta;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      alpha <= 32'sd65536;
      beta <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        spmv_pkg::REG_NUM_ROWS: row_count <= cfg_data[8:0];
        spmv_pkg::REG_NUM_COLS: col_count <= cfg_data[8:0];
        spmv_pkg::REG_ALPHA:    alpha <= cfg_data;
        spmv_pkg::REG_BETA:     beta <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [12:0] rows, cols;
  assign rows = ({4'd0, row_count} > 13'(spmv_pkg::MAX_ROWS)) ? 13'(spmv_pkg::MAX_ROWS) :
                {4'd0, row_count};
  assign cols = ({4'd0, col_count} > 13'(spmv_pkg::MAX_COLS)) ? 13'(spmv_pkg::MAX_COLS) :
                {4'd0, col_count};

  // Captured transaction
  logic [2:0] op;
  logic [10:0] idx;
  logic [7:0] col;
  logic signed [31:0] val;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= in_op;
      idx <= in_index;
      col <= in_column;
      val <= in_value;
    end
  end

  logic [16:0] idx_w;
  assign idx_w = {6'd0, idx};

  logic load_ok;
  always_comb begin
    unique case (op)
      spmv_pkg::OP_LOAD_X:   load_ok = idx_w < {4'd0, cols};
      spmv_pkg::OP_LOAD_Y:   load_ok = idx_w < {4'd0, rows};
      spmv_pkg::OP_LOAD_PTR: load_ok = (idx_w <= {4'd0, rows}) && !val[31] &&
                               ({1'b0, val} <= 33'(spmv_pkg::MAX_NONZEROS));
      spmv_pkg::OP_LOAD_NZ:  load_ok = idx_w < 17'(spmv_pkg::MAX_NONZEROS);
      default:               load_ok = 1'b1;
    endcase
  end

  // Memories
  logic signed [31:0] x_mem [spmv_pkg::MAX_COLS];
  logic signed [31:0] y_mem [spmv_pkg::MAX_ROWS];
  logic [NPW-1:0]     ptr_mem [spmv_pkg::MAX_ROWS+1];
  logic [7:0]         col_mem [spmv_pkg::MAX_NONZEROS];
  logic signed [31:0] nzv_mem [spmv_pkg::MAX_NONZEROS];

  logic signed [31:0] x_q, y_q, nzv_q;
  logic [NPW-1:0] ptr_q;
  logic [7:0] col_q;

  logic [NPW-1:0] start_r, end_r, cursor;
  logic signed [63:0] acc;
  logic signed [31:0] dot_c;
  logic signed [63:0] prod, aprod, bprod;
  logic dot_sat;
  logic signed [31:0] res_c;
  logic res_sat;

  // x memory: load write, read at fetched column
  always_ff @(posedge clk) begin
    if (cmd.do_load && op == spmv_pkg::OP_LOAD_X) x_mem[idx[CW-1:0]] <= val;
    if (cmd.x_rd) x_q <= x_mem[col_q[CW-1:0]];
  end

  // y memory: load or write-back, read of old y
  always_ff @(posedge clk) begin
    if (cmd.do_load && op == spmv_pkg::OP_LOAD_Y) y_mem[idx[RAW-1:0]] <= val;
    else if (cmd.finish) y_mem[idx[RAW-1:0]] <= res_c;
    if (cmd.rd_ptr0) y_q <= y_mem[idx[RAW-1:0]];
  end

  logic [PW-1:0] ptr_ra;
  assign ptr_ra = cmd.rd_ptr0 ? idx[PW-1:0] : PW'(idx_w + 17'd1);
  always_ff @(posedge clk) begin
    if (cmd.do_load && op == spmv_pkg::OP_LOAD_PTR) ptr_mem[idx[PW-1:0]] <= val[NPW-1:0];
    if (cmd.rd_ptr0 || cmd.rd_ptr1) ptr_q <= ptr_mem[ptr_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.do_load && op == spmv_pkg::OP_LOAD_NZ) begin
      col_mem[idx[NW-1:0]] <= col;
      nzv_mem[idx[NW-1:0]] <= val;
    end
    if (cmd.walk_rd) begin
      col_q <= col_mem[cursor[NW-1:0]];
      nzv_q <= nzv_mem[cursor[NW-1:0]];
    end
  end

  // Walk control: row start and end are captured from the pointer reads of rd_ptr0 and rd_ptr1 via delay flags.
  logic ptr1_d, ptr2_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr1_d <= 1'b0;
      ptr2_d <= 1'b0;
    end else begin
      ptr1_d <= cmd.rd_ptr0;
      ptr2_d <= cmd.rd_ptr1;
    end
  end

  always_ff @(posedge clk) begin
    if (ptr1_d) begin
      start_r <= ptr_q;
      cursor <= ptr_q;
    end
    if (ptr2_d) end_r <= ptr_q;
    if (cmd.walk_rd) cursor <= cursor + 1'b1;
  end

  // Product register, then round and accumulate.
  function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t >>> 16;
  endfunction

  assign prod = nzv_q * x_q;
  logic signed [63:0] prod_r;
  always_ff @(posedge clk) prod_r <= prod;

  always_ff @(posedge clk) begin
    if (ptr1_d) acc <= '0;
    else if (cmd.mac) acc <= acc + rnd(prod_r);
  end

  always_comb begin
    dot_sat = 1'b0;
    dot_c = acc[31:0];
    if (acc > 64'sd2147483647) begin
      dot_sat = 1'b1;
      dot_c = 32'sh7fffffff;
    end else if (acc < -64'sd2147483648) begin
      dot_sat = 1'b1;
      dot_c = 32'sh80000000;
    end
  end

  logic signed [31:0] dot_r;
  logic dot_sat_r;
  always_ff @(posedge clk) begin
    if (cmd.clip_dot) begin
      dot_r <= dot_c;
      dot_sat_r <= dot_sat;
    end
    if (cmd.scale_y) begin
      aprod <= rnd(alpha * dot_r);
      bprod <= (beta != 0) ? rnd(beta * y_q) : 64'sd0;
    end
  end

  logic signed [63:0] rsum;
  assign rsum = aprod + bprod;
  always_comb begin
    res_sat = 1'b0;
    res_c = rsum[31:0];
    if (rsum > 64'sd2147483647) begin
      res_sat = 1'b1;
      res_c = 32'sh7fffffff;
    end else if (rsum < -64'sd2147483648) begin
      res_sat = 1'b1;
      res_c = 32'sh80000000;
    end
  end

  // Status back to the controller
  assign stat.is_compute = (op == spmv_pkg::OP_COMPUTE);
  assign stat.op_known = (op <= spmv_pkg::OP_COMPUTE);
  assign stat.load_ok = load_ok;
  assign stat.row_ok = idx_w < {4'd0, rows};
  assign stat.ptr_ok = (start_r <= end_r) && (end_r <= NPW'(spmv_pkg::MAX_NONZEROS));
  assign stat.walk_more = cursor < end_r;
  assign stat.col_ok = {5'd0, col_q} < cols;

  // Output register: a new result wins over the drop of a taken one.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_done) begin
        out_valid <= 1'b1;
        out_row <= '0;
        out_result <= '0;
        out_sat <= 1'b0;
        out_status <= (stat.op_known && !load_ok) ? spmv_pkg::ST_BAD_IDX : spmv_pkg::ST_OK;
      end else if (cmd.fail_idx || cmd.fail_col) begin
        out_valid <= 1'b1;
        out_row <= idx[7:0];
        out_result <= '0;
        out_sat <= 1'b0;
        out_status <= cmd.fail_idx ? spmv_pkg::ST_BAD_IDX : spmv_pkg::ST_BAD_COL;
      end else if (cmd.finish) begin
        out_valid <= 1'b1;
        out_row <= idx[7:0];
        out_result <= res_c;
        out_sat <= dot_sat_r | res_sat;
        out_status <= spmv_pkg::ST_OK;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/csr_sparse_matrix_vector_multiply_core.sv]
`timescale 1ns / 1ps
// Top level of the CSR sparse matrix-vector multiply core, y = alpha*A*x + beta*y.
// Instantiates spmv_ctrl and spmv_datapath; uses spmv_pkg for shared types.
//
//  channel   | dir | handshake              | payload
//  s_axis    | in  | s_axis_tvalid/tready   | tdata: operation, index, column, value
//  m_axis    | out | m_axis_tvalid/tready   | tdata: row_number, row_result, saturated, status
//  cfg       | in  | cfg_we                 | cfg_addr, cfg_data
//
// A load transaction finishes in the decode state. A compute-row transaction
// reads the row pointers, then walks the nonzeros (nonzero read, x read,
// multiply, accumulate), then scales and writes back y. Reset clears control
// state and registers only; memories hold garbage until loaded. A new
// transaction is accepted once the previous result has moved to the output
// register; a stalled output holds the controller in its decode state.
module csr_sparse_matrix_vector_multiply_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // operation[2:0], index[13:3], column[21:14], value[53:22]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // row_number[7:0], row_result[39:8], saturated[40], status[42:41]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data
);

  spmv_pkg::spmv_cmd_t cmd;
  spmv_pkg::spmv_stat_t stat;
  logic busy, in_fire;
  logic [7:0] out_row;
  logic signed [31:0] out_result;
  logic out_sat;
  logic [1:0] out_status;

  // Accept when the controller is idle; the output register parts the sides.
  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  spmv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_free (!m_axis_tvalid || m_axis_tready),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  spmv_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (s_axis_tdata[2:0]),
    .in_index   (s_axis_tdata[13:3]),
    .in_column  (s_axis_tdata[21:14]),
    .in_value   (s_axis_tdata[53:22]),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_row    (out_row),
    .out_result (out_result),
    .out_sat    (out_sat),
    .out_status (out_status)
  );

  assign m_axis_tdata = {5'd0, out_status, out_sat, out_result, out_row};

  // No input accepted while the controller is busy with a load or compute.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready) else $error("accept while busy");

  // A result is produced only by a finishing or failing command.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.finish || cmd.fail_idx || cmd.fail_col ||
                                   cmd.load_done)) else $error("spurious result");

  // Status is never the reserved code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_status != 2'd3)) else $error("bad status");

endmodule
